// ----- design/assert_macros.svh -----
// Assertion macros for the buddy page allocator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define BPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds
`define BPA_NEVER(lbl, cond, msg) \
    `BPA_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/bpa_pkg.sv -----
// Shared types and constants of the buddy page allocator.
// No dependencies; used by bpa_core and buddy_page_allocator.
package bpa_pkg;

    localparam int ORD_W = 4;
    localparam int PG_W  = 10;
    localparam int CNT_W = 11;
    localparam int ST_W  = 2;

    localparam logic [ORD_W-1:0] NOT_HEAD = 4'd15;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [ORD_W-1:0] block_order;
        logic [PG_W-1:0]  page_index;
    } t_req;

    typedef struct packed {
        logic [PG_W-1:0] granted_page;
        logic [ST_W-1:0] status;
    } t_rsp;

    // Control from the top level to the sequencer
    typedef struct packed {
        logic start;
        logic init;
        logic out_free;
        t_req req;
    } t_core_ctl;

    // Completion from the sequencer to the top level
    typedef struct packed {
        logic done;
        logic idle;
        t_rsp rsp;
    } t_core_res;

endpackage

// ----- design/bpa_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bpa_core.sv -----
// Sequencer of the buddy page allocator: table sweep, scan, split and merge.
// Depends on bpa_pkg and bpa_ram (page table of order and busy mark).
module bpa_core #(
    parameter int NUM_PAGES = 1024,
    parameter int MAX_ORDER = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bpa_pkg::t_core_ctl                 i_ctl,
    input  logic [$clog2(NUM_PAGES+1)-1:0]     i_count,
    output bpa_pkg::t_core_res                 o_res
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES+1);
    localparam int DW = bpa_pkg::ORD_W + 1;
    localparam logic [bpa_pkg::ORD_W-1:0] MAXO = bpa_pkg::ORD_W'(MAX_ORDER);
    localparam logic [CW-1:0] LOWMASK = CW'((1 << MAX_ORDER) - 1);
    localparam logic [CW-1:0] LAST    = CW'(NUM_PAGES - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_SPLIT = 11'b00000001000,
        S_FRD   = 11'b00000010000,
        S_FCHK  = 11'b00000100000,
        S_MTEST = 11'b00001000000,
        S_MCHK  = 11'b00010000000,
        S_MHI   = 11'b00100000000,
        S_MLO   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [AW-1:0]               r_pidx, n_pidx;
    logic [bpa_pkg::ORD_W-1:0]   r_best_ord, n_best_ord;
    logic [AW-1:0]               r_best_idx, n_best_idx;
    logic [bpa_pkg::ORD_W-1:0]   r_ord, n_ord;
    logic [bpa_pkg::ORD_W-1:0]   r_k, n_k;
    logic [AW-1:0]               r_base, n_base;
    logic [AW-1:0]               r_p, n_p;
    logic [AW-1:0]               r_b, n_b;
    logic [bpa_pkg::PG_W-1:0]    r_gr, n_gr;
    logic [bpa_pkg::ST_W-1:0]    r_st, n_st;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [DW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [DW-1:0]               ram_rdata;
    logic [bpa_pkg::ORD_W-1:0]   rd_ord;
    logic                        rd_busy;
    logic [CW-1:0]               full;
    logic [bpa_pkg::ORD_W-1:0]   init_ord;
    logic [AW-1:0]               buddy;
    logic                        done;

    assign rd_ord  = ram_rdata[DW-1:1];
    assign rd_busy = ram_rdata[0];
    assign full    = i_count & ~LOWMASK;
    assign buddy   = r_p ^ (AW'(1) << r_ord);

    bpa_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Initial order of the entry under the sweep counter
    always_comb begin
        if (r_idx < full) begin
            init_ord = (r_idx[MAX_ORDER-1:0] == '0) ? MAXO : bpa_pkg::NOT_HEAD;
        end else if (r_idx < i_count) begin
            init_ord = '0;
        end else begin
            init_ord = bpa_pkg::NOT_HEAD;
        end
    end

    // Sequence one request over the shared table port
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_best_ord = r_best_ord;
        n_best_idx = r_best_idx;
        n_ord      = r_ord;
        n_k        = r_k;
        n_base     = r_base;
        n_p        = r_p;
        n_b        = r_b;
        n_gr       = r_gr;
        n_st       = r_st;
        ram_we     = 1'b0;
        ram_waddr  = r_base;
        ram_wdata  = '0;
        ram_raddr  = r_p;
        done       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_k  = i_ctl.req.block_order;
                    n_gr = '0;
                    n_st = bpa_pkg::ST_DONE;
                    if (i_ctl.req.opcode == bpa_pkg::OP_ALLOC) begin
                        if (i_ctl.req.block_order > MAXO) begin
                            n_st    = bpa_pkg::ST_NOSPACE;
                            n_state = S_DONE;
                        end else begin
                            n_idx      = '0;
                            n_pend     = 1'b0;
                            n_best_ord = bpa_pkg::NOT_HEAD;
                            n_state    = S_SCAN;
                        end
                    end else begin
                        if (i_ctl.req.block_order > MAXO ||
                            32'(i_ctl.req.page_index) >= 32'(i_count)) begin
                            n_st    = bpa_pkg::ST_BADFREE;
                            n_state = S_DONE;
                        end else begin
                            n_p     = AW'(i_ctl.req.page_index);
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = {init_ord, 1'b0};
                if (r_idx == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                // Issue one read a cycle, check the entry read the cycle before
                ram_raddr = r_idx[AW-1:0];
                if (r_pend && !rd_busy && rd_ord >= r_k && rd_ord <= MAXO &&
                    rd_ord < r_best_ord) begin
                    n_best_ord = rd_ord;
                    n_best_idx = r_pidx;
                end
                if (r_idx < i_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && r_idx >= i_count) begin
                    if (r_best_ord == bpa_pkg::NOT_HEAD) begin
                        n_st    = bpa_pkg::ST_NOSPACE;
                        n_state = S_DONE;
                    end else begin
                        n_ord   = r_best_ord;
                        n_base  = r_best_idx;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                // Free lower half, go to upper half; at asked order, mark busy
                ram_we    = 1'b1;
                ram_waddr = r_base;
                if (r_ord > r_k) begin
                    ram_wdata = {r_ord - 1'b1, 1'b0};
                    n_base    = r_base + (AW'(1) << (r_ord - 1'b1));
                    n_ord     = r_ord - 1'b1;
                end else begin
                    ram_wdata = {r_k, 1'b1};
                    n_gr      = bpa_pkg::PG_W'(r_base);
                    n_state   = S_DONE;
                end
            end
            S_FRD: begin
                ram_raddr = r_p;
                n_state   = S_FCHK;
            end
            S_FCHK: begin
                if (!rd_busy || rd_ord != r_k) begin
                    n_st    = bpa_pkg::ST_BADFREE;
                    n_state = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_p;
                    ram_wdata = {r_k, 1'b0};
                    n_ord     = r_k;
                    n_state   = S_MTEST;
                end
            end
            S_MTEST: begin
                ram_raddr = buddy;
                n_b       = buddy;
                if (r_ord >= MAXO || 32'(buddy) >= 32'(i_count)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                if (rd_ord != r_ord || rd_busy) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MHI;
                end
            end
            S_MHI: begin
                ram_we    = 1'b1;
                ram_waddr = (r_b < r_p) ? r_p : r_b;
                ram_wdata = {bpa_pkg::NOT_HEAD, 1'b0};
                n_state   = S_MLO;
            end
            S_MLO: begin
                ram_we    = 1'b1;
                ram_waddr = (r_b < r_p) ? r_b : r_p;
                ram_wdata = {r_ord + 1'b1, 1'b0};
                n_p       = (r_b < r_p) ? r_b : r_p;
                n_ord     = r_ord + 1'b1;
                n_state   = S_MTEST;
            end
            S_DONE: begin
                if (i_ctl.out_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Restart the table sweep on a count write
        if (i_ctl.init) begin
            n_idx   = '0;
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_best_ord <= n_best_ord;
        r_best_idx <= n_best_idx;
        r_ord      <= n_ord;
        r_k        <= n_k;
        r_base     <= n_base;
        r_p        <= n_p;
        r_b        <= n_b;
        r_gr       <= n_gr;
        r_st       <= n_st;
    end

    assign o_res.done             = done;
    assign o_res.idle             = (r_state == S_IDLE);
    assign o_res.rsp.granted_page = r_gr;
    assign o_res.rsp.status       = r_st;

endmodule

// ----- design/buddy_page_allocator.sv -----
// Buddy page allocator: allocate scans the table over the managed pages, one
// read a cycle, then writes once per split; free reads and checks the block,
// then tests and merges buddies. One request at a time. Reset, and every
// page_count write, sweep the whole table with the input not ready. Depends on
// bpa_pkg, bpa_core and assert_macros.svh.
`include "assert_macros.svh"

module buddy_page_allocator #(
    parameter int NUM_PAGES = 1024,
    parameter int MAX_ORDER = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bpa_pkg::t_req              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bpa_pkg::t_rsp              o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bpa_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int CW      = $clog2(NUM_PAGES+1);
    localparam int RST_CNT = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;

    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid;
    bpa_pkg::t_rsp       r_out_data;
    bpa_pkg::t_core_ctl  ctl;
    bpa_pkg::t_core_res  res;
    logic                cfg_wr;
    logic                in_acc;
    logic                out_failed;

    // Hold off a request beat while a count write is offered
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = res.idle && !i_cfg_valid;
    assign in_acc      = i_in_valid && o_in_ready;

    // Saturate the written count to the table depth
    assign n_count = (32'(i_cfg_data) > 32'(NUM_PAGES)) ? CW'(NUM_PAGES)
                                                         : CW'(i_cfg_data);

    assign ctl.start    = in_acc;
    assign ctl.init     = cfg_wr;
    assign ctl.out_free = !r_out_valid;
    assign ctl.req      = i_in_data;

    bpa_core #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_count (r_count),
        .o_res   (res)
    );

    // Hold the page count; drop the result beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CW'(RST_CNT);
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_count <= n_count;
            end
            if (res.done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_out_data <= res.rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_failed  = (r_out_data.status != bpa_pkg::ST_DONE);

    `BPA_NEVER(a_done_into_full, res.done && r_out_valid, "result over a pending beat")
    `BPA_ASSERT(a_busy_after_accept, in_acc |=> !o_in_ready, "ready right after accept")
    `BPA_NEVER(a_grant_on_fail, r_out_valid && out_failed && r_out_data.granted_page != '0, "grant")

endmodule

// ----- tb/buddy_page_allocator_tb.sv -----
// Testbench for buddy_page_allocator: directed and random allocate/free beats
// against a behavioral page table. Depends on bpa_pkg and the design files.
`timescale 1ns / 100ps

module buddy_page_allocator_tb;

    localparam int NPG      = 1024;
    localparam int MAXO     = 8;
    localparam int LIMIT    = 20000000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    bpa_pkg::t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    bpa_pkg::t_rsp o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [bpa_pkg::CNT_W-1:0] i_cfg_data;

    buddy_page_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow page table
    logic [bpa_pkg::ORD_W-1:0] tbl_order [NPG];
    logic                      tbl_busy  [NPG];
    int unsigned               tbl_count;

    bpa_pkg::t_rsp grant_q [$];
    int   fail_cnt;
    int   cyc;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_recv;
    // Busy blocks handed out, for well-formed frees
    logic [bpa_pkg::PG_W-1:0]  held_page [$];
    logic [bpa_pkg::ORD_W-1:0] held_ord  [$];

    function automatic int unsigned managed();
        return (tbl_count > NPG) ? NPG : tbl_count;
    endfunction

    function automatic void table_init();
        int unsigned n;
        int unsigned full;
        n = managed();
        full = n & ~32'(255);
        for (int i = 0; i < NPG; i++) begin
            tbl_busy[i] = 1'b0;
            if (i < full) begin
                tbl_order[i] = ((i & 255) == 0) ? bpa_pkg::ORD_W'(MAXO) : bpa_pkg::NOT_HEAD;
            end else if (i < n) begin
                tbl_order[i] = '0;
            end else begin
                tbl_order[i] = bpa_pkg::NOT_HEAD;
            end
        end
    endfunction

    function automatic bpa_pkg::t_rsp predict_grant(bpa_pkg::t_req rq);
        bpa_pkg::t_rsp r;
        int unsigned n, k, o, base, p, b, lo, hi;
        bit found;
        n = managed();
        k = rq.block_order;
        r.granted_page = '0;
        r.status = bpa_pkg::ST_DONE;
        found = 0;
        base = 0;
        if (rq.opcode == bpa_pkg::OP_ALLOC) begin
            if (k > MAXO) begin
                r.status = bpa_pkg::ST_NOSPACE;
                return r;
            end
            for (o = k; o <= MAXO && !found; o++)
                for (int i = 0; i < n && !found; i++)
                    if (tbl_order[i] == o && !tbl_busy[i]) begin
                        base = i;
                        found = 1;
                    end
            if (!found) begin
                r.status = bpa_pkg::ST_NOSPACE;
                return r;
            end
            o--;
            while (o > k) begin
                o--;
                tbl_order[base] = bpa_pkg::ORD_W'(o);
                base += 1 << o;
            end
            tbl_order[base] = bpa_pkg::ORD_W'(k);
            tbl_busy[base] = 1'b1;
            r.granted_page = bpa_pkg::PG_W'(base);
            held_page.push_back(bpa_pkg::PG_W'(base));
            held_ord.push_back(bpa_pkg::ORD_W'(k));
        end else begin
            p = rq.page_index;
            if (k > MAXO || p >= n || !tbl_busy[p] || tbl_order[p] != k) begin
                r.status = bpa_pkg::ST_BADFREE;
                return r;
            end
            tbl_busy[p] = 1'b0;
            for (o = k; o < MAXO; o++) begin
                b = p ^ (1 << o);
                if (b >= n || tbl_order[b] != o || tbl_busy[b]) break;
                lo = (b < p) ? b : p;
                hi = (b < p) ? p : b;
                tbl_order[hi] = bpa_pkg::NOT_HEAD;
                tbl_order[lo] = bpa_pkg::ORD_W'(o + 1);
                p = lo;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_cnt++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Drive receiver ready at falling edge
    always @(negedge i_clk) begin
        if (hold_recv) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                bpa_pkg::t_rsp w;
                w = grant_q.pop_front();
                if (o_out_data.granted_page !== w.granted_page)
                    report_mismatch("granted_page", o_out_data.granted_page, w.granted_page);
                if (o_out_data.status !== w.status)
                    report_mismatch("status", o_out_data.status, w.status);
            end
        end
    end

    // Offer one request beat at the falling edge and hold it until taken
    task automatic send_req(logic op, logic [bpa_pkg::ORD_W-1:0] ord,
                            logic [bpa_pkg::PG_W-1:0] pg);
        bpa_pkg::t_req rq;
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        rq.opcode = op;
        rq.block_order = ord;
        rq.page_index = pg;
        i_in_data = rq;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        grant_q.push_back(predict_grant(rq));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (grant_q.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic write_count(logic [bpa_pkg::CNT_W-1:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tbl_count = v;
        table_init();
        held_page.delete();
        held_ord.delete();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Free one held block picked at random
    task automatic free_held();
        int j;
        j = $urandom_range(held_page.size() - 1);
        send_req(bpa_pkg::OP_FREE, held_ord[j], held_page[j]);
        held_page.delete(j);
        held_ord.delete(j);
    endtask

    task automatic test_directed();
        send_req(bpa_pkg::OP_ALLOC, 4'd0, 10'h3ff);
        send_req(bpa_pkg::OP_ALLOC, 4'd8, 10'd0);
        send_req(bpa_pkg::OP_ALLOC, 4'd9, 10'd0);
        send_req(bpa_pkg::OP_ALLOC, 4'd15, 10'd0);
        send_req(bpa_pkg::OP_FREE, 4'd15, 10'd0);
        send_req(bpa_pkg::OP_FREE, 4'd0, 10'd5);
        send_req(bpa_pkg::OP_FREE, 4'd3, 10'h3ff);
        while (held_page.size() != 0) free_held();
        for (int i = 0; i < 5; i++) send_req(bpa_pkg::OP_ALLOC, 4'd8, 10'd0);
        send_req(bpa_pkg::OP_FREE, 4'd8, 10'd768);
        send_req(bpa_pkg::OP_FREE, 4'd8, 10'd768);
        write_count(11'd300);
        send_req(bpa_pkg::OP_ALLOC, 4'd1, 10'd0);
        send_req(bpa_pkg::OP_ALLOC, 4'd0, 10'd0);
        send_req(bpa_pkg::OP_FREE, 4'd0, 10'd299);
        send_req(bpa_pkg::OP_FREE, 4'd0, 10'd300);
        write_count(11'd0);
        send_req(bpa_pkg::OP_ALLOC, 4'd0, 10'd0);
        send_req(bpa_pkg::OP_FREE, 4'd0, 10'd0);
        write_count(11'h7ff);
        send_req(bpa_pkg::OP_ALLOC, 4'd2, 10'd0);
        send_req(bpa_pkg::OP_ALLOC, 4'd8, 10'd0);
    endtask

    // Mostly well-formed alloc/free mix with some noise
    task automatic test_random(int items);
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_req(bpa_pkg::OP_ALLOC, bpa_pkg::ORD_W'($urandom_range(MAXO)),
                         bpa_pkg::PG_W'($urandom));
            end else if (r < 85 && held_page.size() != 0) begin
                free_held();
            end else begin
                send_req(logic'($urandom), bpa_pkg::ORD_W'($urandom),
                         bpa_pkg::PG_W'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(20);
        join
    endtask

    initial begin
        fail_cnt = 0;
        hold_recv = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 71;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        tbl_count = NPG;
        table_init();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(500);
        write_count(11'd1024);
        send_idle_pct = 71;
        recv_idle_pct = 17;
        test_random(500);
        test_backpressure();
        write_count(11'd517);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);
        write_count(11'd1024);
        test_random(400);
        drain();

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_core.sv
design/buddy_page_allocator.sv
tb/buddy_page_allocator_tb.sv
